[rtl/core/ascp_pkg.sv]
package ascp_pkg;

    localparam int unsigned DIGIT_LIMIT = 15;
    localparam int unsigned DIGIT_CNT_W = $clog2(DIGIT_LIMIT + 1);

    localparam int unsigned CHAR_IN_W  = 8;
    localparam int unsigned CHAR_OUT_W = 7;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned PARAM_W    = 8;
    localparam int unsigned PROD_W     = 12;

    localparam logic [CHAR_IN_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_IN_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_IN_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_IN_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHAR_IN_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_IN_W-1:0] CH_M     = 8'h6D;
    localparam logic [CHAR_IN_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_IN_W-1:0] CH_NINE  = 8'h39;

    localparam logic [PARAM_W-1:0] SGR_RESET   = 8'd0;
    localparam logic [PARAM_W-1:0] SGR_FG_BASE = 8'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_LAST = 8'd37;
    localparam logic [PARAM_W-1:0] SGR_BG_BASE = 8'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_LAST = 8'd47;
    localparam logic [PARAM_W-1:0] PARAM_MAX   = 8'd255;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

    typedef logic [COLOR_W-1:0] color_t;

    function automatic color_t palette_lookup(input logic [2:0] idx);
        color_t c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'hAA0000;
            3'd2:    c = 24'h00AA00;
            3'd3:    c = 24'hAA5500;
            3'd4:    c = 24'h0000AA;
            3'd5:    c = 24'hAA00AA;
            3'd6:    c = 24'h00AAAA;
            3'd7:    c = 24'hAAAAAA;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/ansi_sgr_color_parser.sv]
// A byte in 0x20..0x7F or a newline shows on m_valid in the cycle after its input transfer.
// Throughput: one byte per cycle; s_ready stays high while the result register is empty
// or being drained, so the only stall source is m_ready held low with a result waiting.
// Parser state and colors update in the same cycle as the input transfer.
// Reset (aresetn low, synchronous): normal mode, empty parameter, white on black,
// result register empty.
module ansi_sgr_color_parser
    import ascp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_IN_W-1:0]  s_char_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_OUT_W-1:0] m_char_out,
    output logic [COLOR_W-1:0]    m_fg_color,
    output logic [COLOR_W-1:0]    m_bg_color
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    mode_t                   mode_reg, mode_next;
    logic [DIGIT_CNT_W-1:0]  digit_cnt_reg, digit_cnt_next;
    logic [PARAM_W-1:0]      param_reg, param_next;
    color_t                  fg_reg, fg_next;
    color_t                  bg_reg, bg_next;

    logic                    m_valid_reg;
    logic [CHAR_OUT_W-1:0]   char_out_reg;
    color_t                  fg_out_reg;
    color_t                  bg_out_reg;

    logic                    s_xfer;
    logic                    emit;
    logic                    is_digit;
    logic                    apply_en;
    logic [PROD_W-1:0]       accum;
    logic [PARAM_W-1:0]      fg_off;
    logic [PARAM_W-1:0]      bg_off;

    // The result register is the only buffer: take a new byte whenever it is
    // empty or its current result leaves this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    assign is_digit = (s_char_in >= CH_ZERO) && (s_char_in <= CH_NINE);

    // param * 10 + digit, at most 2559; saturate to a byte.
    assign accum = ({4'd0, param_reg} << 3) + ({4'd0, param_reg} << 1)
                 + {4'd0, s_char_in - CH_ZERO};

    assign fg_off = param_reg - SGR_FG_BASE;
    assign bg_off = param_reg - SGR_BG_BASE;

    // Apply the SGR code on ';' always, on 'm' only when a digit was seen.
    always_comb begin
        apply_en = 1'b0;
        if (mode_reg == MODE_CSI) begin
            if (s_char_in == CH_SEMI) begin
                apply_en = 1'b1;
            end else if (s_char_in == CH_M) begin
                apply_en = (digit_cnt_reg != '0);
            end
        end
    end

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (apply_en) begin
            if (param_reg == SGR_RESET) begin
                fg_next = COLOR_WHITE;
                bg_next = COLOR_BLACK;
            end else if (param_reg >= SGR_FG_BASE && param_reg <= SGR_FG_LAST) begin
                fg_next = palette_lookup(fg_off[2:0]);
            end else if (param_reg >= SGR_BG_BASE && param_reg <= SGR_BG_LAST) begin
                bg_next = palette_lookup(bg_off[2:0]);
            end
        end
    end

    // Mode and parameter sequencing.
    always_comb begin
        mode_next      = mode_reg;
        digit_cnt_next = digit_cnt_reg;
        param_next     = param_reg;
        emit           = 1'b0;
        case (mode_reg)
            MODE_ESC: begin
                if (s_char_in == CH_LBRK) begin
                    mode_next      = MODE_CSI;
                    digit_cnt_next = '0;
                    param_next     = '0;
                end else begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_CSI: begin
                if (is_digit) begin
                    // Drop digits past the limit.
                    if (digit_cnt_reg < DIGIT_CNT_W'(DIGIT_LIMIT)) begin
                        param_next     = (accum > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                                     : accum[PARAM_W-1:0];
                        digit_cnt_next = digit_cnt_reg + 1'b1;
                    end
                end else if (s_char_in == CH_SEMI) begin
                    digit_cnt_next = '0;
                    param_next     = '0;
                end else if (s_char_in == CH_M) begin
                    digit_cnt_next = '0;
                    param_next     = '0;
                    mode_next      = MODE_NORMAL;
                end else begin
                    // Abort the sequence; a pending parameter is dropped.
                    mode_next = MODE_NORMAL;
                end
            end
            default: begin
                if (s_char_in == CH_ESC) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_NORMAL;
                    emit      = (s_char_in == CH_LF)
                             || (s_char_in >= CH_SPACE && !s_char_in[CHAR_IN_W-1]);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NORMAL;
            digit_cnt_reg <= '0;
            param_reg     <= '0;
            fg_reg        <= COLOR_WHITE;
            bg_reg        <= COLOR_BLACK;
            m_valid_reg   <= 1'b0;
            char_out_reg  <= '0;
            fg_out_reg    <= '0;
            bg_out_reg    <= '0;
        end else begin
            if (s_xfer) begin
                mode_reg      <= mode_next;
                digit_cnt_reg <= digit_cnt_next;
                param_reg     <= param_next;
                fg_reg        <= fg_next;
                bg_reg        <= bg_next;
                m_valid_reg   <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Result payload: load only with a transfer that produces output.
            if (s_xfer && emit) begin
                char_out_reg <= s_char_in[CHAR_OUT_W-1:0];
                fg_out_reg   <= fg_reg;
                bg_out_reg   <= bg_reg;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_char_out = char_out_reg;
    assign m_fg_color = fg_out_reg;
    assign m_bg_color = bg_out_reg;

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && emit) |=> m_valid_reg)
        else $error("emitted byte did not reach the result register");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_out == CH_LF[CHAR_OUT_W-1:0]
                      || m_char_out >= CH_SPACE[CHAR_OUT_W-1:0]))
        else $error("result byte is neither newline nor printable");

    a_digit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_cnt_reg <= DIGIT_CNT_W'(DIGIT_LIMIT))
        else $error("digit count past limit");

    a_empty_param: assert property (@(posedge aclk) disable iff (!aresetn)
        (digit_cnt_reg == '0) |-> (param_reg == '0))
        else $error("parameter value without digits");

    a_esc_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && mode_reg == MODE_ESC) |=> (mode_reg != MODE_ESC))
        else $error("escape mode held past one byte");

    a_no_emit_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && mode_reg != MODE_NORMAL) |-> !emit)
        else $error("output produced inside an escape sequence");

endmodule
